@@ sv/hsl_pkg.sv @@
`default_nettype none
package hsl_pkg;

    localparam int unsigned ValW  = 17;
    localparam int unsigned HueW  = 16;
    localparam int unsigned ProdW = 2 * ValW;

    localparam logic [ValW-1:0] One       = 17'd65536;
    localparam logic [ValW-1:0] Half      = 17'd32768;
    localparam logic [HueW-1:0] ThirdTurn = 16'd21845;

    localparam logic [1:0] RegRise = 2'd0;
    localparam logic [1:0] RegTop  = 2'd1;
    localparam logic [1:0] RegFall = 2'd2;
    localparam logic [1:0] RegLow  = 2'd3;

    typedef struct packed {
        logic [1:0]      region;
        logic [ValW-1:0] op;
    } t_chan;

endpackage
`default_nettype wire

@@ sv/hsl_to_rgb_converter.sv @@
// hsl to rgb pixel converter, four register stages
// a beat accepted into stage one moves on through stages two and three to the output register of stage four
// throughput: one beat per cycle; a stall on the output holds every stage in place
// reset (synchronous, active low) empties the pipeline; data registers are not reset
// multipliers: one l*s product in stage one, three ramp products in stage three
`default_nettype none
module hsl_to_rgb_converter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [55:0] i_s_tdata,   // hue[15:0], saturation[32:16], lightness[49:33]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [55:0]      o_m_tdata    // red[16:0], green[33:17], blue[50:34]
);

    localparam int unsigned VW = hsl_pkg::ValW;
    localparam int unsigned HW = hsl_pkg::HueW;
    localparam int unsigned PW = hsl_pkg::ProdW;

    logic en;

    logic           r_v1, r_v2, r_v3, r_v4;

    // stage 1
    logic [HW-1:0]  r_hue1, n_hue1;
    logic [VW-1:0]  r_s1, n_s1, r_l1, n_l1;
    logic [PW-1:0]  r_prod1, n_prod1;

    // stage 2
    logic [VW-1:0]  r_p2, n_p2, r_q2, n_q2, r_d2, n_d2;
    hsl_pkg::t_chan r_ch2 [3];
    hsl_pkg::t_chan n_ch2 [3];

    // stage 3
    logic [VW-1:0]  r_p3, r_q3;
    logic [1:0]     r_reg3 [3];
    logic [PW-1:0]  r_m3 [3];
    logic [PW-1:0]  n_m3 [3];

    // stage 4
    logic [VW-1:0]  r_out4 [3];
    logic [VW-1:0]  n_out4 [3];

    assign en         = !r_v4 || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = {5'd0, r_out4[2], r_out4[1], r_out4[0]};

    always_comb begin
        logic [VW-1:0] s_in, l_in;
        s_in = i_s_tdata[32:16];
        l_in = i_s_tdata[49:33];
        n_hue1  = i_s_tdata[15:0];
        n_s1    = (s_in > hsl_pkg::One) ? hsl_pkg::One : s_in;
        n_l1    = (l_in > hsl_pkg::One) ? hsl_pkg::One : l_in;
        n_prod1 = n_l1 * n_s1;
    end

    always_comb begin
        logic [PW-1:0]   rsum;
        logic [VW-1:0]   rnd;
        logic [VW:0]     q_raw;
        logic signed [VW+2:0] p_raw;
        logic [HW-1:0]   t [3];
        logic [HW+2:0]   t6;
        logic [HW+1:0]   t3;
        rsum = r_prod1 + PW'(hsl_pkg::Half);
        rnd  = rsum[VW+15:16];
        if (r_l1 < hsl_pkg::Half) begin
            q_raw = {1'b0, r_l1} + {1'b0, rnd};
        end else begin
            q_raw = {1'b0, r_l1} + {1'b0, r_s1} - {1'b0, rnd};
        end
        n_q2  = (q_raw > {1'b0, hsl_pkg::One}) ? hsl_pkg::One : q_raw[VW-1:0];
        p_raw = $signed({2'b00, r_l1, 1'b0}) - $signed({3'b000, n_q2});
        if (p_raw < 0) begin
            n_p2 = '0;
        end else if (p_raw > $signed({3'b000, n_q2})) begin
            n_p2 = n_q2;
        end else begin
            n_p2 = p_raw[VW-1:0];
        end
        n_d2 = n_q2 - n_p2;
        t[0] = r_hue1 + hsl_pkg::ThirdTurn;
        t[1] = r_hue1;
        t[2] = r_hue1 - hsl_pkg::ThirdTurn;
        for (int c = 0; c < 3; c++) begin
            t6 = {1'b0, t[c], 2'b00} + {2'b00, t[c], 1'b0};
            t3 = {2'b00, t[c]} + {1'b0, t[c], 1'b0};
            if (t6 < (HW+3)'(hsl_pkg::One)) begin
                n_ch2[c].region = hsl_pkg::RegRise;
                n_ch2[c].op     = t6[VW-1:0];
            end else if (!t[c][HW-1]) begin
                n_ch2[c].region = hsl_pkg::RegTop;
                n_ch2[c].op     = '0;
            end else if (t3 < {hsl_pkg::One, 1'b0}) begin
                n_ch2[c].region = hsl_pkg::RegFall;
                n_ch2[c].op     = VW'({hsl_pkg::One, 2'b00} - t6);
            end else begin
                n_ch2[c].region = hsl_pkg::RegLow;
                n_ch2[c].op     = '0;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_m3[c] = r_d2 * r_ch2[c].op;
        end
    end

    always_comb begin
        logic [PW-1:0] rsum;
        logic [VW:0]   sum;
        for (int c = 0; c < 3; c++) begin
            rsum = r_m3[c] + PW'(hsl_pkg::Half);
            sum  = {1'b0, r_p3} + {1'b0, rsum[VW+15:16]};
            unique case (r_reg3[c])
                hsl_pkg::RegRise,
                hsl_pkg::RegFall: begin
                    n_out4[c] = (sum > {1'b0, hsl_pkg::One}) ? hsl_pkg::One : sum[VW-1:0];
                end
                hsl_pkg::RegTop: begin
                    n_out4[c] = r_q3;
                end
                default: begin
                    n_out4[c] = r_p3;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hue1  <= n_hue1;
            r_s1    <= n_s1;
            r_l1    <= n_l1;
            r_prod1 <= n_prod1;
            r_p2    <= n_p2;
            r_q2    <= n_q2;
            r_d2    <= n_d2;
            r_p3    <= r_p2;
            r_q3    <= r_q2;
            for (int c = 0; c < 3; c++) begin
                r_ch2[c]  <= n_ch2[c];
                r_reg3[c] <= r_ch2[c].region;
                r_m3[c]   <= n_m3[c];
                r_out4[c] <= n_out4[c];
            end
        end
    end

endmodule
`default_nettype wire
